FILE: hw/rtl/sramc_pkg.sv
// Shared constants, types and register codes of the send-rate mode controller.
package sramc_pkg;

	localparam int WINDOW_SAMPLES = 8;
	localparam int TIME_BITS      = 40;
	localparam int TS_W           = 40;
	localparam int CT_W           = 32;
	localparam int RATIO_W        = 16;
	localparam int THRESH_W       = 32;
	localparam int SAT_W          = 32;

	localparam int RING_DEPTH = WINDOW_SAMPLES + 1;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int FILL_W     = $clog2(RING_DEPTH + 1);

	localparam int AVG_W   = TIME_BITS - ($clog2(WINDOW_SAMPLES + 1) - 1);
	localparam int AVGX_W  = (AVG_W > SAT_W + 1) ? AVG_W : SAT_W + 1;
	localparam int PROD_W  = RATIO_W + AVG_W;
	localparam int CT256_W = CT_W + 8;
	localparam int RCMP_W  = (PROD_W > CT256_W) ? PROD_W : CT256_W;
	localparam int HPROD_W = SAT_W + RATIO_W;
	localparam int HCMP_W  = (HPROD_W > AVG_W + 8) ? HPROD_W : AVG_W + 8;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int S_DATA_W   = 72;
	localparam int M_DATA_W   = 40;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_RATIO        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RATIO        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HYST_FACTOR      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUAL_UP          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_QUAL_DOWN        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COMPLEX_EN       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_START_COMPRESSED = 3'd6;

	localparam logic [RATIO_W-1:0]  MAX_RATIO_RST   = 16'd128;
	localparam logic [RATIO_W-1:0]  MIN_RATIO_RST   = 16'd64;
	localparam logic [RATIO_W-1:0]  HYST_FACTOR_RST = 16'd256;
	localparam logic [THRESH_W-1:0] QUAL_UP_RST     = 32'd40000;
	localparam logic [THRESH_W-1:0] QUAL_DOWN_RST   = 32'd60000;
	localparam logic                COMPLEX_EN_RST  = 1'b0;
	localparam logic                START_COMP_RST  = 1'b1;

	typedef enum logic [1:0] {
		QUAL_NONE = 2'd0,
		QUAL_UP   = 2'd1,
		QUAL_DOWN = 2'd2
	} qual_t;

	typedef struct packed {
		logic [RATIO_W-1:0]  max_ratio;
		logic [RATIO_W-1:0]  min_ratio;
		logic [RATIO_W-1:0]  hyst_factor;
		logic [THRESH_W-1:0] qual_up;
		logic [THRESH_W-1:0] qual_down;
		logic                complex_en;
	} cfg_t;

	typedef struct packed {
		qual_t              quality_request;
		logic               compression_changed;
		logic               compressed_now;
		logic [SAT_W-1:0]   average_interval_us;
		logic               average_valid;
	} res_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} pipe_valid_t;

endpackage

FILE: hw/rtl/sramc_ring.sv
// Timestamp ring memory with its write pointer and registered read of the oldest entry.
module sramc_ring (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [sramc_pkg::TIME_BITS-1:0]    wr_ts,
	output logic [sramc_pkg::TIME_BITS-1:0]    oldest_ts
);

	logic [sramc_pkg::TIME_BITS-1:0] mem [sramc_pkg::RING_DEPTH];
	logic [sramc_pkg::RING_AW-1:0]   head_q;
	logic [sramc_pkg::RING_AW-1:0]   next_addr;
	logic [sramc_pkg::TIME_BITS-1:0] rd_q;

	always_comb begin
		if (head_q == sramc_pkg::RING_AW'(sramc_pkg::RING_DEPTH - 1)) begin
			next_addr = '0;
		end else begin
			next_addr = head_q + sramc_pkg::RING_AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (wr_en) begin
			head_q <= next_addr;
		end
	end

	// The slot after the head holds the word written a whole window ago.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[head_q] <= wr_ts;
			rd_q        <= mem[next_addr];
		end
	end

	assign oldest_ts = rd_q;

endmodule

FILE: hw/rtl/sramc_decide.sv
// Average, ratio products and mode decision pipeline with the controller state.
module sramc_decide (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sramc_pkg::cfg_t                   cfg,
	input  logic                              in_valid,
	input  logic [sramc_pkg::TIME_BITS-1:0]   in_ts,
	input  logic [sramc_pkg::CT_W-1:0]        in_ct,
	input  logic [sramc_pkg::TIME_BITS-1:0]   oldest_ts,
	output sramc_pkg::pipe_valid_t            pipe_valid,
	output logic                              res_valid,
	output sramc_pkg::res_t                   res
);

	// Stage 1
	logic                            v_s1;
	logic [sramc_pkg::TIME_BITS-1:0] ts_s1;
	logic [sramc_pkg::CT_W-1:0]      ct_s1;
	logic [sramc_pkg::TIME_BITS-1:0] diff;
	logic [sramc_pkg::AVG_W-1:0]     avg_d;

	// Stage 2
	logic                            v_s2;
	logic [sramc_pkg::AVG_W-1:0]     avg_s2;
	logic [sramc_pkg::CT_W-1:0]      ct_s2;
	logic [sramc_pkg::AVGX_W-1:0]    avgx;
	logic [sramc_pkg::SAT_W-1:0]     sat_d;
	logic                            fwd_wr;
	logic [sramc_pkg::SAT_W-1:0]     last_c_use;
	logic [sramc_pkg::SAT_W-1:0]     last_u_use;
	logic                            c_vld_use;
	logic                            u_vld_use;

	// Stage 3
	logic                            v_s3;
	logic [sramc_pkg::SAT_W-1:0]     sat_s3;
	logic [sramc_pkg::RCMP_W-1:0]    max_prod_s3;
	logic [sramc_pkg::RCMP_W-1:0]    min_prod_s3;
	logic [sramc_pkg::RCMP_W-1:0]    ct256_s3;
	logic [sramc_pkg::HCMP_W-1:0]    hc_s3;
	logic [sramc_pkg::HCMP_W-1:0]    hu_s3;
	logic [sramc_pkg::HCMP_W-1:0]    avg256_s3;
	logic                            c_vld_s3;
	logic                            u_vld_s3;
	logic                            qup_s3;
	logic                            qdn_s3;

	// Controller state
	logic [sramc_pkg::FILL_W-1:0]    fill_q;
	logic                            flag_q;
	logic [sramc_pkg::SAT_W-1:0]     last_c_q;
	logic [sramc_pkg::SAT_W-1:0]     last_u_q;
	logic                            c_vld_q;
	logic                            u_vld_q;

	logic                            wnd_full;
	logic                            leave_ok;
	logic                            enter_ok;
	logic                            changed;
	logic                            flag_d;
	sramc_pkg::qual_t                qual_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			ts_s1 <= in_ts;
			ct_s1 <= in_ct;
		end
	end

	always_comb begin
		diff  = ts_s1 - oldest_ts;
		avg_d = sramc_pkg::AVG_W'(diff / sramc_pkg::WINDOW_SAMPLES);
	end

	always_ff @(posedge clk) begin
		avg_s2 <= avg_d;
		ct_s2  <= ct_s1;
	end

	assign wnd_full = (fill_q == sramc_pkg::FILL_W'(sramc_pkg::WINDOW_SAMPLES));

	// The word in stage 3 updates one of the last averages at this edge; forward it.
	always_comb begin
		avgx       = sramc_pkg::AVGX_W'(avg_s2);
		sat_d      = (|avgx[sramc_pkg::AVGX_W-1:sramc_pkg::SAT_W]) ? '1
		             : avgx[sramc_pkg::SAT_W-1:0];
		fwd_wr     = v_s3 && wnd_full;
		last_c_use = (fwd_wr && flag_q) ? sat_s3 : last_c_q;
		last_u_use = (fwd_wr && !flag_q) ? sat_s3 : last_u_q;
		c_vld_use  = (fwd_wr && flag_q) || c_vld_q;
		u_vld_use  = (fwd_wr && !flag_q) || u_vld_q;
	end

	always_ff @(posedge clk) begin
		sat_s3      <= sat_d;
		max_prod_s3 <= sramc_pkg::RCMP_W'(sramc_pkg::PROD_W'(cfg.max_ratio)
		               * sramc_pkg::PROD_W'(avg_s2));
		min_prod_s3 <= sramc_pkg::RCMP_W'(sramc_pkg::PROD_W'(cfg.min_ratio)
		               * sramc_pkg::PROD_W'(avg_s2));
		ct256_s3    <= sramc_pkg::RCMP_W'({ct_s2, 8'h00});
		hc_s3       <= sramc_pkg::HCMP_W'(sramc_pkg::HPROD_W'(last_c_use)
		               * sramc_pkg::HPROD_W'(cfg.hyst_factor));
		hu_s3       <= sramc_pkg::HCMP_W'(sramc_pkg::HPROD_W'(last_u_use)
		               * sramc_pkg::HPROD_W'(cfg.hyst_factor));
		avg256_s3   <= sramc_pkg::HCMP_W'({avg_s2, 8'h00});
		c_vld_s3    <= c_vld_use;
		u_vld_s3    <= u_vld_use;
		qup_s3      <= avgx < sramc_pkg::AVGX_W'(cfg.qual_up);
		qdn_s3      <= avgx > sramc_pkg::AVGX_W'(cfg.qual_down);
	end

	always_comb begin
		leave_ok = (ct256_s3 > max_prod_s3) && (!u_vld_s3 || (hu_s3 < avg256_s3));
		enter_ok = (ct256_s3 < min_prod_s3) && (!c_vld_s3 || (hc_s3 < avg256_s3));
		changed  = v_s3 && wnd_full && (flag_q ? leave_ok : enter_ok);
		flag_d   = flag_q ^ changed;
		qual_d   = sramc_pkg::QUAL_NONE;
		if (wnd_full && !changed && cfg.complex_en) begin
			priority if (qup_s3) begin
				qual_d = sramc_pkg::QUAL_UP;
			end else if (qdn_s3) begin
				qual_d = sramc_pkg::QUAL_DOWN;
			end else begin
				qual_d = sramc_pkg::QUAL_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			flag_q  <= sramc_pkg::START_COMP_RST;
			c_vld_q <= 1'b0;
			u_vld_q <= 1'b0;
		end else if (v_s3) begin
			flag_q <= flag_d;
			priority if (changed) begin
				fill_q <= '0;
			end else if (!wnd_full) begin
				fill_q <= fill_q + sramc_pkg::FILL_W'(1);
			end else begin
				fill_q <= fill_q;
			end
			if (wnd_full) begin
				if (flag_q) begin
					c_vld_q <= 1'b1;
				end else begin
					u_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && wnd_full) begin
			if (flag_q) begin
				last_c_q <= sat_s3;
			end else begin
				last_u_q <= sat_s3;
			end
		end
	end

	always_comb begin
		res.average_valid       = wnd_full;
		res.average_interval_us = wnd_full ? sat_s3 : '0;
		res.compressed_now      = flag_d;
		res.compression_changed = changed;
		res.quality_request     = qual_d;
	end

	assign res_valid     = v_s3;
	assign pipe_valid.s1 = v_s1;
	assign pipe_valid.s2 = v_s2;
	assign pipe_valid.s3 = v_s3;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= sramc_pkg::FILL_W'(sramc_pkg::WINDOW_SAMPLES))
		else $error("Window fill count exceeds the window size.");

	a_change_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.compression_changed |=> fill_q == '0)
		else $error("A mode change did not empty the window.");

	a_change_needs_avg: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.compression_changed |-> res.average_valid)
		else $error("Mode changed without a full window.");

	a_change_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.compression_changed |=> flag_q != $past(flag_q))
		else $error("Mode change did not toggle the compression state.");

	a_quality_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.quality_request != sramc_pkg::QUAL_NONE
		|-> !res.compression_changed && cfg.complex_en)
		else $error("Quality request issued together with a mode change.");
`endif

endmodule

FILE: hw/rtl/sramc_ofifo.sv
// Result queue between the decision pipeline and the output stream.
module sramc_ofifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  sramc_pkg::res_t                 push_data,
	input  logic                            pop_ready,
	output logic                            pop_valid,
	output sramc_pkg::res_t                 pop_data,
	output logic [sramc_pkg::FIFO_CW-1:0]   count
);

	sramc_pkg::res_t                  mem_q [sramc_pkg::FIFO_DEPTH];
	logic [sramc_pkg::FIFO_AW-1:0]    wr_ptr_q;
	logic [sramc_pkg::FIFO_AW-1:0]    rd_ptr_q;
	logic [sramc_pkg::FIFO_CW-1:0]    count_q;
	logic                             pop;

	assign pop_valid = (count_q != '0);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = mem_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == sramc_pkg::FIFO_AW'(sramc_pkg::FIFO_DEPTH - 1)) ? '0
				            : wr_ptr_q + sramc_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == sramc_pkg::FIFO_AW'(sramc_pkg::FIFO_DEPTH - 1)) ? '0
				            : rd_ptr_q + sramc_pkg::FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + sramc_pkg::FIFO_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - sramc_pkg::FIFO_CW'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/send_rate_adaptive_mode_controller.sv
// Top level of the send-rate adaptive compression-mode controller.
// Each input word reports one finished frame send: its timestamp and the
// compression time measured now. Each accepted word yields exactly one output
// word with the average send interval over the last eight intervals, the
// compression state, whether it changed, and an optional quality request.
// A word is taken on the s_ side when s_tvalid and s_tready are both high and
// is given on the m_ side when m_tvalid and m_tready are both high.
// An accepted word passes the decision pipeline and then the result queue before
// m_tvalid; throughput is one word per cycle while s_tready is high, set by the
// single timestamp memory port used once per word and the three-stage decision pipeline.
// Configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while no word is in flight, which the block
// does not enforce. A write to start_compressed has no effect; reset always
// starts compressed, restores every register, empties the timestamp window
// and forgets the last averages of both modes. With a stalled receiver up to
// eight results queue; s_tready falls once queue and pipeline hold eight words.
module send_rate_adaptive_mode_controller (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sramc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sramc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// send_timestamp_us [39:0], compress_time_us [71:40]
	input  logic [sramc_pkg::S_DATA_W-1:0]       s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// average_valid [0], average_interval_us [32:1], compressed_now [33],
	// compression_changed [34], quality_request [36:35], zero [39:37]
	output logic [sramc_pkg::M_DATA_W-1:0]       m_tdata
);

	sramc_pkg::cfg_t                     cfg_q;
	logic                                accept;
	logic [sramc_pkg::TIME_BITS-1:0]     ts_in;
	logic [sramc_pkg::CT_W-1:0]          ct_in;
	logic [sramc_pkg::TIME_BITS-1:0]     oldest_ts;
	sramc_pkg::pipe_valid_t              pipe_valid;
	logic                                res_valid;
	sramc_pkg::res_t                     res;
	sramc_pkg::res_t                     out_res;
	logic [sramc_pkg::FIFO_CW-1:0]       fifo_count;
	logic [sramc_pkg::FIFO_CW:0]         held;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_ratio   <= sramc_pkg::MAX_RATIO_RST;
			cfg_q.min_ratio   <= sramc_pkg::MIN_RATIO_RST;
			cfg_q.hyst_factor <= sramc_pkg::HYST_FACTOR_RST;
			cfg_q.qual_up     <= sramc_pkg::QUAL_UP_RST;
			cfg_q.qual_down   <= sramc_pkg::QUAL_DOWN_RST;
			cfg_q.complex_en  <= sramc_pkg::COMPLEX_EN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sramc_pkg::REG_MAX_RATIO: begin
					cfg_q.max_ratio <= cfg_data[sramc_pkg::RATIO_W-1:0];
				end
				sramc_pkg::REG_MIN_RATIO: begin
					cfg_q.min_ratio <= cfg_data[sramc_pkg::RATIO_W-1:0];
				end
				sramc_pkg::REG_HYST_FACTOR: begin
					cfg_q.hyst_factor <= cfg_data[sramc_pkg::RATIO_W-1:0];
				end
				sramc_pkg::REG_QUAL_UP: begin
					cfg_q.qual_up <= cfg_data[sramc_pkg::THRESH_W-1:0];
				end
				sramc_pkg::REG_QUAL_DOWN: begin
					cfg_q.qual_down <= cfg_data[sramc_pkg::THRESH_W-1:0];
				end
				sramc_pkg::REG_COMPLEX_EN: begin
					cfg_q.complex_en <= cfg_data[0];
				end
				sramc_pkg::REG_START_COMPRESSED: begin
					cfg_q <= cfg_q;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Every word in flight has a queue slot reserved, so the queue never overflows.
	always_comb begin
		held = (sramc_pkg::FIFO_CW + 1)'(fifo_count)
		       + (sramc_pkg::FIFO_CW + 1)'(pipe_valid.s1)
		       + (sramc_pkg::FIFO_CW + 1)'(pipe_valid.s2)
		       + (sramc_pkg::FIFO_CW + 1)'(pipe_valid.s3);
		s_tready = held < (sramc_pkg::FIFO_CW + 1)'(sramc_pkg::FIFO_DEPTH);
	end

	assign accept = s_tvalid && s_tready;
	assign ts_in  = sramc_pkg::TIME_BITS'(s_tdata[sramc_pkg::TS_W-1:0]);
	assign ct_in  = s_tdata[sramc_pkg::TS_W +: sramc_pkg::CT_W];

	sramc_ring u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (accept),
		.wr_ts     (ts_in),
		.oldest_ts (oldest_ts)
	);

	sramc_decide u_decide (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (accept),
		.in_ts      (ts_in),
		.in_ct      (ct_in),
		.oldest_ts  (oldest_ts),
		.pipe_valid (pipe_valid),
		.res_valid  (res_valid),
		.res        (res)
	);

	sramc_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop_ready (m_tready),
		.pop_valid (m_tvalid),
		.pop_data  (out_res),
		.count     (fifo_count)
	);

	assign m_tdata = {3'b000, out_res.quality_request, out_res.compression_changed,
	                  out_res.compressed_now, out_res.average_interval_us,
	                  out_res.average_valid};

endmodule
